// ===== design/lls_pkg.sv =====
// ----------------------------------------------------------------------------
// lls_pkg: shared types and constants of the life-like automaton step
// Cell state codes, register indexes, register widths and the flag set that
// describes the results of one accepted cell.
// ----------------------------------------------------------------------------
package lls_pkg;

  // Widths of the configuration registers and of a cell state.
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int MASK_W       = 9;
  localparam int CFG_DATA_W   = 13;
  localparam int STATE_W      = 2;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH  = 4;

  // Cell state codes. The spare code is handled as always alive.
  localparam logic [STATE_W-1:0] ST_DEAD   = 2'd0;
  localparam logic [STATE_W-1:0] ST_ALIVE  = 2'd1;
  localparam logic [STATE_W-1:0] ST_ALWAYS = 2'd2;
  localparam logic [STATE_W-1:0] ST_SPARE  = 2'd3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_BIRTH_MASK   = 2'd2,
    REG_SURVIVE_MASK = 2'd3
  } reg_index_t;

  // Results caused by one accepted cell: an interior update, a border
  // pass-through, or both, plus the end-of-generation mark.
  typedef struct packed {
    logic               upd_valid;
    logic [STATE_W-1:0] upd_state;
    logic               brd_valid;
    logic [STATE_W-1:0] brd_state;
    logic               done;
  } lls_flags_t;

  // Count of live neighbors among eight cells.
  function automatic logic [3:0] count_live(input logic [7:0] live);
    logic [3:0] sum;
    sum = 4'd0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'd0, live[i]};
    end
    return sum;
  endfunction

endpackage

// ===== design/life_like_automaton_step.sv =====
// Path: a result passes the stage one registers, the queue and the output register.
// Throughput: one cell per cycle while the queue has room. A row-end cell from the third
// row on has two results, offset by the resultless second column, which the four-entry
// queue absorbs; along the last row most cells have two results and intake slows.
// Reset: synchronous; clears position counters, window, queue and output
// register, and loads the default grid size and rule masks.
// ----------------------------------------------------------------------------
// life_like_automaton_step: one generation of a three-state life-like grid
// Streams cells in raster order, keeps two rows of history and emits the new
// state of every cell with its coordinates.
// ----------------------------------------------------------------------------
module life_like_automaton_step import lls_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [STATE_W-1:0]                cell_state,
  output logic                              empty,
  input  logic                              pop,
  output logic [$clog2(MAX_WIDTH)-1:0]      cell_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]     cell_row,
  output logic [STATE_W-1:0]                new_state,
  output logic                              last_of_run,
  output logic                              generation_done,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int FW     = $bits(lls_flags_t);
  localparam int DATA_W = FW + CW + RW;

  logic [WIDTH_REG_W-1:0]  grid_width;
  logic [HEIGHT_REG_W-1:0] grid_height;
  logic [MASK_W-1:0]       birth_mask;
  logic [MASK_W-1:0]       survive_mask;

  logic                    enq_valid;
  lls_flags_t              enq_flags;
  logic [CW-1:0]           enq_col;
  logic [RW-1:0]           enq_row;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_pop;
  logic [DATA_W-1:0]       q_data;
  lls_flags_t              q_flags;
  logic [CW-1:0]           q_col;
  logic [RW-1:0]           q_row;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= WIDTH_REG_W'(1500);
      grid_height  <= HEIGHT_REG_W'(900);
      birth_mask   <= MASK_W'(488);
      survive_mask <= MASK_W'(480);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH:   grid_width   <= cfg_data[WIDTH_REG_W-1:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[HEIGHT_REG_W-1:0];
        REG_BIRTH_MASK:   birth_mask   <= cfg_data[MASK_W-1:0];
        REG_SURVIVE_MASK: survive_mask <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Intake and classification.
  lls_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .cell_state   (cell_state),
    .full         (full),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .birth_mask   (birth_mask),
    .survive_mask (survive_mask),
    .q_full       (q_full),
    .enq_valid    (enq_valid),
    .enq_flags    (enq_flags),
    .enq_col      (enq_col),
    .enq_row      (enq_row)
  );

  // Queue between front and back.
  lls_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (enq_valid),
    .push_data ({enq_flags, enq_col, enq_row}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign {q_flags, q_col, q_row} = q_data;

  // Result delivery.
  lls_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_flags         (q_flags),
    .q_col           (q_col),
    .q_row           (q_row),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .cell_col        (cell_col),
    .cell_row        (cell_row),
    .new_state       (new_state),
    .last_of_run     (last_of_run),
    .generation_done (generation_done)
  );

  // The queue is never written while it is full.
  assert property (@(posedge clk) disable iff (rst) enq_valid |-> !q_full)
    else $error("queue written while full");

  // The back never takes an entry from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");

  // The end of a generation is always the last result of its cell.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && generation_done) |-> last_of_run)
    else $error("generation end without end of run");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

endmodule

// ===== design/lls_front.sv =====
// ----------------------------------------------------------------------------
// lls_front: cell intake, row stores, 3x3 window and classification
// Accepts one cell per cycle unless full is high, tracks its coordinates,
// reads the two row stores, and one stage later forms the window, computes
// the interior update and hands the results of the cell to the queue.
// ----------------------------------------------------------------------------
module lls_front import lls_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [STATE_W-1:0]                cell_state,
  output logic                              full,
  input  logic [WIDTH_REG_W-1:0]            grid_width,
  input  logic [HEIGHT_REG_W-1:0]           grid_height,
  input  logic [MASK_W-1:0]                 birth_mask,
  input  logic [MASK_W-1:0]                 survive_mask,
  input  logic                              q_full,
  output logic                              enq_valid,
  output lls_flags_t                        enq_flags,
  output logic [$clog2(MAX_WIDTH)-1:0]      enq_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]     enq_row
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]      w_last;
  logic [RW-1:0]      h_last;
  logic [CW-1:0]      col_cnt;
  logic [RW-1:0]      row_cnt;
  logic [STATE_W-1:0] cell_in;
  logic               accept;
  logic               advance;
  logic               row_end;
  logic               last_row;
  logic               do_upd;
  logic               do_brd;

  // Stage one registers.
  logic               s1_valid;
  logic [CW-1:0]      s1_col;
  logic [RW-1:0]      s1_row;
  logic [STATE_W-1:0] s1_cell;
  logic               s1_upd;
  logic               s1_brd;
  logic               s1_done;

  // Row stores and their registered read data.
  logic [STATE_W-1:0] upper_mem  [MAX_WIDTH];
  logic [STATE_W-1:0] middle_mem [MAX_WIDTH];
  logic [STATE_W-1:0] rd_top;
  logic [STATE_W-1:0] rd_mid;

  logic [17:0]        window;
  logic [17:0]        window_next;
  logic [7:0]         live;
  logic [3:0]         count;
  logic [STATE_W-1:0] centre;
  logic [STATE_W-1:0] upd_state;

  // Clamp the grid size to the supported range and keep the last index.
  always_comb begin
    if (grid_width < WIDTH_REG_W'(3)) begin
      w_last = CW'(2);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(32'(grid_width) - 32'd1);
    end
    if (grid_height < HEIGHT_REG_W'(3)) begin
      h_last = RW'(2);
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(32'(grid_height) - 32'd1);
    end
  end

  // Handshake: stage one moves on whenever the queue has room.
  assign advance = !q_full;
  assign full    = s1_valid && q_full;
  assign accept  = push && !full;

  // Classify the incoming cell by its position.
  always_comb begin
    cell_in  = (cell_state == ST_SPARE) ? ST_ALWAYS : cell_state;
    row_end  = col_cnt >= w_last;
    last_row = row_cnt >= h_last;
    do_upd   = (row_cnt >= RW'(2)) && (col_cnt >= CW'(2)) &&
               (row_cnt <= h_last) && (col_cnt <= w_last);
    do_brd   = (row_cnt == '0) || last_row || (col_cnt == '0) || row_end;
  end

  // Raster position of the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // Stage one valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= col_cnt;
      s1_row  <= row_cnt;
      s1_cell <= cell_in;
      s1_upd  <= do_upd;
      s1_brd  <= do_brd;
      s1_done <= row_end && last_row;
    end
  end

  // Row stores: read on intake, shift the column down one row in stage one.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_top <= upper_mem[col_cnt];
      rd_mid <= middle_mem[col_cnt];
    end
    if (s1_valid && advance) begin
      upper_mem[s1_col]  <= rd_mid;
      middle_mem[s1_col] <= s1_cell;
    end
  end

  // Window shift and neighbor count.
  always_comb begin
    window_next = {window[11:0], rd_top, rd_mid, s1_cell};
    live = {s1_cell != ST_DEAD, rd_mid != ST_DEAD, rd_top != ST_DEAD,
            window[1:0] != ST_DEAD, window[5:4] != ST_DEAD,
            window[7:6] != ST_DEAD, window[9:8] != ST_DEAD,
            window[11:10] != ST_DEAD};
    count  = count_live(live);
    centre = window[3:2];
    case (centre)
      ST_ALWAYS: upd_state = ST_ALWAYS;
      ST_ALIVE:  upd_state = {1'b0, survive_mask[count]};
      default:   upd_state = {1'b0, birth_mask[count]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid && advance) begin
      window <= window_next;
    end
  end

  // Hand the results of the cell to the queue; cells with none are dropped.
  always_comb begin
    enq_valid           = s1_valid && advance && (s1_upd || s1_brd);
    enq_flags.upd_valid = s1_upd;
    enq_flags.upd_state = upd_state;
    enq_flags.brd_valid = s1_brd;
    enq_flags.brd_state = s1_cell;
    enq_flags.done      = s1_done;
    enq_col             = s1_col;
    enq_row             = s1_row;
  end

endmodule

// ===== design/lls_queue.sv =====
// ----------------------------------------------------------------------------
// lls_queue: short queue between the front and the back
// Holds the classified cells so that intake and result delivery stall on
// their own.
// ----------------------------------------------------------------------------
module lls_queue import lls_pkg::*; #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [NW-1:0]     fill;

  assign full     = fill == NW'(QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = slots[head];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= tail + PW'(1);
      end
      if (pop) begin
        head <= head + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

// ===== design/lls_back.sv =====
// ----------------------------------------------------------------------------
// lls_back: result delivery
// Expands each queued cell into one or two result transactions, the interior
// update first, and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
module lls_back import lls_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  lls_flags_t                        q_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0]      q_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     q_row,
  output logic                              q_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic [$clog2(MAX_WIDTH)-1:0]      cell_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]     cell_row,
  output logic [STATE_W-1:0]                new_state,
  output logic                              last_of_run,
  output logic                              generation_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic out_valid;
  logic phase;
  logic load;
  logic send_upd;
  logic two_results;

  // Load a new result whenever the output register is free or being taken.
  always_comb begin
    load        = !q_empty && (!out_valid || pop);
    send_upd    = q_flags.upd_valid && !phase;
    two_results = send_upd && q_flags.brd_valid;
    q_pop       = load && !two_results;
  end

  assign empty = !out_valid;

  // Output valid flag and the step within a two-result cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= two_results;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      if (send_upd) begin
        cell_col        <= q_col - CW'(1);
        cell_row        <= q_row - RW'(1);
        new_state       <= q_flags.upd_state;
        last_of_run     <= !q_flags.brd_valid;
        generation_done <= !q_flags.brd_valid && q_flags.done;
      end else begin
        cell_col        <= q_col;
        cell_row        <= q_row;
        new_state       <= q_flags.brd_state;
        last_of_run     <= 1'b1;
        generation_done <= q_flags.done;
      end
    end
  end

endmodule
